// ===== sv/ssfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Start/stop frame parser package
// Shared types and constants for the byte-serial frame parser.
// ----------------------------------------------------------------------------
package ssfp_pkg;

  localparam logic [7:0] START_BYTE_RESET = 8'd240;
  localparam logic [7:0] STOP_BYTE_RESET  = 8'd247;

  localparam logic [8:0] TYPE_POS    = 9'd4;
  localparam logic [8:0] LEN_POS     = 9'd5;
  localparam logic [8:0] PAYLOAD_POS = 9'd6;
  localparam logic [8:0] POS_MAX     = 9'd511;

  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_STOP_BYTE  = 1'b1;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_index;
    logic [7:0] payload_value;
    logic [7:0] reply_count;
    logic       length_match;
    logic [7:0] frame_type;
    logic [7:0] declared_length;
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] header_third;
    logic [7:0] trailer_value;
  } result_t;

  typedef struct packed {
    logic       wr_en;
    logic       index;
    logic [7:0] data;
  } cfg_t;

endpackage

// ===== sv/ssfp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module ssfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== sv/ssfp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parse stage
// Keeps the frame state and the captured fields, and works out the result
// that one byte causes.
// ----------------------------------------------------------------------------
module ssfp_parse (
  input  logic            clk,
  input  logic            rst,
  input  ssfp_pkg::cfg_t  cfg,
  input  logic            advance,
  input  logic [7:0]      byte_in,
  output logic            res_hit,
  output ssfp_pkg::result_t res
);
  import ssfp_pkg::*;

  logic [7:0] start_byte;
  logic [7:0] stop_byte;

  logic       in_frame;
  logic [8:0] position;
  logic [7:0] payload_count;
  logic [7:0] length_reg;
  logic [7:0] type_reg;
  logic [7:0] header_regs [3];
  logic [7:0] footer_reg;

  logic       in_frame_next;
  logic [8:0] position_next;
  logic [7:0] payload_count_next;
  logic [7:0] length_reg_next;
  logic [7:0] type_reg_next;
  logic [7:0] header_next [3];
  logic [7:0] footer_reg_next;

  logic       start_hit;
  logic       stop_hit;
  logic       frame_a;
  logic [8:0] pos_a;
  logic [7:0] cnt_b;
  logic [9:0] payload_end;
  logic       have_payload;
  logic [8:0] pay_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      stop_byte  <= STOP_BYTE_RESET;
    end else if (cfg.wr_en) begin
      unique case (cfg.index)
        CFG_START_BYTE: start_byte <= cfg.data;
        CFG_STOP_BYTE:  stop_byte  <= cfg.data;
        default:        start_byte <= start_byte;
      endcase
    end
  end

  always_comb begin
    start_hit = (byte_in == start_byte);
    stop_hit  = (byte_in == stop_byte);
    frame_a   = start_hit || in_frame;
    pos_a     = start_hit ? 9'd0 : position;
    cnt_b     = start_hit ? 8'd0 : payload_count;

    length_reg_next = length_reg;
    type_reg_next   = type_reg;
    header_next     = header_regs;
    footer_reg_next = footer_reg;
    have_payload    = 1'b0;
    pay_off         = pos_a - PAYLOAD_POS;
    payload_end     = {1'b0, PAYLOAD_POS} + {2'b00, length_reg};
    position_next   = pos_a;

    if (frame_a) begin
      priority if (pos_a == 9'd0) begin
        have_payload = 1'b0;
      end else if (pos_a < TYPE_POS) begin
        header_next[pos_a[1:0] - 2'd1] = byte_in;
      end else if (pos_a == TYPE_POS) begin
        type_reg_next = byte_in;
      end else if (pos_a == LEN_POS) begin
        length_reg_next = byte_in;
      end else if ({1'b0, pos_a} < payload_end) begin
        cnt_b        = cnt_b + 8'd1;
        have_payload = 1'b1;
      end else if ({1'b0, pos_a} == payload_end) begin
        footer_reg_next = byte_in;
      end else begin
        have_payload = 1'b0;
      end
      if (pos_a < POS_MAX) begin
        position_next = pos_a + 9'd1;
      end
    end

    if (stop_hit) begin
      in_frame_next      = 1'b0;
      payload_count_next = 8'd0;
      position_next      = 9'd0;
    end else begin
      in_frame_next      = frame_a;
      payload_count_next = cnt_b;
    end

    res_hit             = stop_hit || have_payload;
    res.kind            = stop_hit ? KIND_FRAME_END : KIND_PAYLOAD;
    res.payload_index   = stop_hit ? 8'd0 : pay_off[7:0];
    res.payload_value   = stop_hit ? 8'd0 : byte_in;
    res.reply_count     = cnt_b;
    res.length_match    = (cnt_b == length_reg_next);
    res.frame_type      = type_reg_next;
    res.declared_length = length_reg_next;
    res.header_first    = header_next[0];
    res.header_second   = header_next[1];
    res.header_third    = header_next[2];
    res.trailer_value   = footer_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      position       <= 9'd0;
      payload_count  <= 8'd0;
      length_reg     <= 8'd0;
      type_reg       <= 8'd0;
      header_regs[0] <= 8'd0;
      header_regs[1] <= 8'd0;
      header_regs[2] <= 8'd0;
      footer_reg     <= 8'd0;
    end else if (advance) begin
      in_frame      <= in_frame_next;
      position      <= position_next;
      payload_count <= payload_count_next;
      length_reg    <= length_reg_next;
      type_reg      <= type_reg_next;
      header_regs   <= header_next;
      footer_reg    <= footer_reg_next;
    end
  end

endmodule

// ===== sv/ssfp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ssfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ssfp_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfp_pkg::result_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== sv/start_stop_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Start/stop frame parser core
// Parses a stream of received bytes into payload items and frame-end replies.
// ----------------------------------------------------------------------------
// Bytes enter on the rx_byte channel (in_valid/in_ready) and results leave on
// the output channel (out_valid/out_ready); an item moves when valid and ready
// are both high. Each byte gives zero or one result item: a payload item for
// every payload byte, or a frame-end reply when the byte equals the stop byte.
// A byte is held in the input register and is parsed on its way into the result
// register, so a result is presented once its byte has passed through both
// registers. One byte is taken every cycle while
// the receiver keeps up; the single compare-and-update pass of the parse stage
// sets that rate.
// When the receiver stalls, the result register holds its item and the input
// register holds one more byte, then in_ready drops until the result is taken.
// Reset sets the start byte to 240 and the stop byte to 247, closes any frame
// and clears all captured fields. The user must write the start and stop bytes
// via cfg_wr_en/cfg_index/cfg_data while no item is in flight; unenforced.
// ----------------------------------------------------------------------------
module start_stop_frame_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] payload_index,
  output logic [7:0] payload_value,
  output logic [7:0] reply_count,
  output logic       length_match,
  output logic [7:0] frame_type,
  output logic [7:0] declared_length,
  output logic [7:0] header_first,
  output logic [7:0] header_second,
  output logic [7:0] header_third,
  output logic [7:0] trailer_value
);
  import ssfp_pkg::*;

  cfg_t       cfg;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       res_hit;
  result_t    res;
  result_t    res_q;

  assign cfg.wr_en = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign advance = held_valid && (!out_valid || out_ready);

  ssfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ssfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .byte_in (held_byte),
    .res_hit (res_hit),
    .res     (res)
  );

  ssfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_hit),
    .res_in    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign kind            = res_q.kind;
  assign payload_index   = res_q.payload_index;
  assign payload_value   = res_q.payload_value;
  assign reply_count     = res_q.reply_count;
  assign length_match    = res_q.length_match;
  assign frame_type      = res_q.frame_type;
  assign declared_length = res_q.declared_length;
  assign header_first    = res_q.header_first;
  assign header_second   = res_q.header_second;
  assign header_third    = res_q.header_third;
  assign trailer_value   = res_q.trailer_value;

endmodule
